[src/crg_pkg.sv]
// Shared widths, register map and carried-data types for the camera ray generator.
// Depends on nothing; every other file imports it.
package crg_pkg;

   localparam int MAT_W        = 32;   // Q16.16 matrix and eye entries
   localparam int MATRIX_FRAC  = 16;
   localparam int COORD_FRAC   = 4;
   localparam int SCR_W        = 16;
   localparam int DIR_W        = 16;
   localparam int DIR_FRAC     = 15;

   localparam int CSR_DATA_W   = 64;
   localparam int NUM_REGS     = 8;
   localparam int REG_IDX_W    = $clog2(NUM_REGS);
   localparam int ADDR_W       = REG_IDX_W + 3;

   localparam logic [REG_IDX_W-1:0] REG_COL_X01 = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_COL_X23 = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_COL_Y01 = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_COL_Y23 = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_COL_C01 = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_COL_C23 = 3'd5;
   localparam logic [REG_IDX_W-1:0] REG_EYE_XY  = 3'd6;
   localparam logic [REG_IDX_W-1:0] REG_EYE_Z   = 3'd7;

   localparam logic [CSR_DATA_W-1:0] COL_C23_RESET = 64'h0000_0001_0000_0000;

   // Transform
   localparam int PROD_W = MAT_W + SCR_W + 1;
   localparam int VW     = 51;           // homogeneous vector element, signed
   localparam int MAG_W  = VW - 1;

   // Perspective divide: quotient of |v|*2^16 by |w|
   localparam int WORLD_W     = 48;      // signed world coordinate
   localparam int SAT_SHIFT   = WORLD_W - 1 - MATRIX_FRAC;
   localparam int PDIV_BITS   = 48;
   localparam int PDIV_STEPS  = 2;
   localparam int PDIV_STAGES = PDIV_BITS / PDIV_STEPS;
   localparam int PREM_W      = MAG_W + 1;
   localparam logic [WORLD_W-2:0] WORLD_MAX = '1;

   // Normalisation
   localparam int DIFF_W = WORLD_W + 1;
   localparam int MG_W   = WORLD_W;
   localparam int POS_W  = $clog2(MG_W);
   localparam int NORM_W = 30;
   localparam int SQ_W   = 2 * NORM_W;
   localparam int SUM_W  = SQ_W + 2;

   // Square root
   localparam int ROOT_W     = 32;
   localparam int SQ_IN_W    = 2 * ROOT_W;
   localparam int RT_REM_W   = ROOT_W + 2;
   localparam int SQRT_STEPS = 2;
   localparam int SQRT_STAGES = ROOT_W / SQRT_STEPS;
   localparam int LEN_W      = ROOT_W - 1;

   // Unit divide
   localparam int NUM_W       = NORM_W + DIR_FRAC + 1;
   localparam int UQ_BITS     = 18;
   localparam int UDIV_STEPS  = 2;
   localparam int UDIV_STAGES = UQ_BITS / UDIV_STEPS;
   localparam int UREM_W      = LEN_W + 1;
   localparam logic [UQ_BITS-1:0] DIR_POS_MAX = 18'd32767;
   localparam logic [UQ_BITS-1:0] DIR_NEG_MAX = 18'd32768;

   typedef logic [3:0][MAT_W-1:0]   col_type;
   typedef logic [2:0][MAT_W-1:0]   eye_type;
   typedef logic [3:0][VW-1:0]      vec4_type;
   typedef logic [2:0][WORLD_W-1:0] world_type;

   // Data that travels beside the length through the square root.
   typedef struct packed {
      logic                    valid;
      logic                    degen;
      logic [2:0]              neg;
      logic [2:0][NORM_W-1:0]  mag;
   } ray_side_type;

endpackage

[src/camera_ray_generator_unit.sv]
// Top level of the camera ray generator: register file, port handling and the pipeline.
// Depends on crg_pkg, crg_transform, crg_persp_div, crg_normalize, crg_isqrt, crg_unit_div.
//
// Usage:
//   A screen position is taken on req_screen_x/req_screen_y at each rising edge where
//   start is high and busy is low. busy is never raised, so a new beat may be started
//   in every cycle and the block sustains one ray per clock.
//   Each beat yields one result: rsp_strobe is high for a single cycle once the beat has
//   left the pipeline, with the unit direction on rsp_dir_x/y/z (signed Q1.15) and
//   rsp_degenerate set when w or the eye-relative vector was zero (directions are then
//   zero). The pipeline holds two transform stages, the perspective divider (27 stages,
//   24 of them two quotient bits each), six normalisation stages, the square root
//   (16 stages) and the unit divider (11 stages). Results leave in order.
//   The receiver cannot hold results off; there is no backpressure anywhere.
//   The matrix columns and eye position are written through the APB-style port, one
//   64-bit register per 8-byte slot, and should only change while no beat is in flight.
//   The ray origin is the eye register itself.
//   A synchronous reset empties the pipeline and restores the registers: all zero
//   except row 3 of the translation column, which becomes one raw unit.
module camera_ray_generator_unit import crg_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [SCR_W-1:0]      req_screen_x,
   input  logic [SCR_W-1:0]      req_screen_y,
   output logic                  rsp_strobe,
   output logic [DIR_W-1:0]      rsp_dir_x,
   output logic [DIR_W-1:0]      rsp_dir_y,
   output logic [DIR_W-1:0]      rsp_dir_z,
   output logic                  rsp_degenerate,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [ADDR_W-1:0]     paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   localparam int LATENCY = 62;

   logic [CSR_DATA_W-1:0] regs_ff [NUM_REGS];
   logic [REG_IDX_W-1:0]  reg_idx;
   logic                  wr_en;

   col_type          col_x, col_y, col_c;
   eye_type          eye;
   logic             in_valid;
   logic             tr_valid;
   vec4_type         tr_v;
   logic             pd_valid, pd_wzero;
   world_type        pd_world;
   ray_side_type     nm_side, sq_side;
   logic [SUM_W-1:0] nm_sum;
   logic [LEN_W-1:0] sq_len;

   assign busy     = 1'b0;
   assign pready   = 1'b1;
   assign in_valid = start & ~busy;
   assign reg_idx  = paddr[ADDR_W-1:3];
   assign wr_en    = psel & penable & pwrite & pready;
   assign prdata   = regs_ff[reg_idx];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_REGS; i++) begin
            regs_ff[i] <= '0;
         end
         regs_ff[REG_COL_C23] <= COL_C23_RESET;
      end else if (wr_en) begin
         if (reg_idx == REG_EYE_Z) begin
            regs_ff[reg_idx] <= {{(CSR_DATA_W-MAT_W){1'b0}}, pwdata[MAT_W-1:0]};
         end else begin
            regs_ff[reg_idx] <= pwdata;
         end
      end
   end

   assign col_x = {regs_ff[REG_COL_X23], regs_ff[REG_COL_X01]};
   assign col_y = {regs_ff[REG_COL_Y23], regs_ff[REG_COL_Y01]};
   assign col_c = {regs_ff[REG_COL_C23], regs_ff[REG_COL_C01]};
   assign eye   = {regs_ff[REG_EYE_Z][MAT_W-1:0], regs_ff[REG_EYE_XY]};

   crg_transform u_transform (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (in_valid),
      .screen_x  (req_screen_x),
      .screen_y  (req_screen_y),
      .col_x     (col_x),
      .col_y     (col_y),
      .col_c     (col_c),
      .out_valid (tr_valid),
      .v         (tr_v)
   );

   crg_persp_div u_persp_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (tr_valid),
      .v         (tr_v),
      .out_valid (pd_valid),
      .out_wzero (pd_wzero),
      .world     (pd_world)
   );

   crg_normalize u_normalize (
      .clock    (clock),
      .reset    (reset),
      .in_valid (pd_valid),
      .in_wzero (pd_wzero),
      .world    (pd_world),
      .eye      (eye),
      .side     (nm_side),
      .sum      (nm_sum)
   );

   crg_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .in_side  (nm_side),
      .sum      (nm_sum),
      .out_side (sq_side),
      .len      (sq_len)
   );

   crg_unit_div u_unit_div (
      .clock      (clock),
      .reset      (reset),
      .in_side    (sq_side),
      .len        (sq_len),
      .out_valid  (rsp_strobe),
      .dir_x      (rsp_dir_x),
      .dir_y      (rsp_dir_y),
      .dir_z      (rsp_dir_z),
      .degenerate (rsp_degenerate)
   );

`ifndef SYNTHESIS
   a_start_gives_result: assert property (@(posedge clock) disable iff (reset)
      in_valid |-> ##LATENCY rsp_strobe)
      else $error("start beat produced no result beat");

   a_result_has_start: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(in_valid, LATENCY))
      else $error("result beat without a matching start beat");

   a_degenerate_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_degenerate |->
         rsp_dir_x == '0 && rsp_dir_y == '0 && rsp_dir_z == '0)
      else $error("degenerate result carries a non-zero direction");

   a_unit_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_degenerate |->
         rsp_dir_x != '0 || rsp_dir_y != '0 || rsp_dir_z != '0)
      else $error("valid direction is all zero");
`endif

endmodule

[src/crg_transform.sv]
// Two-stage screen-to-homogeneous transform: v = Mx*x + My*y + Mc*2^C.
// Depends on crg_pkg.
module crg_transform import crg_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  logic [SCR_W-1:0] screen_x,
   input  logic [SCR_W-1:0] screen_y,
   input  col_type          col_x,
   input  col_type          col_y,
   input  col_type          col_c,
   output logic             out_valid,
   output vec4_type         v
);

   logic signed [PROD_W-1:0] prod_x_in [4];
   logic signed [PROD_W-1:0] prod_y_in [4];
   logic signed [PROD_W-1:0] prod_x_ff [4];
   logic signed [PROD_W-1:0] prod_y_ff [4];
   logic                     valid_a_ff;
   logic                     valid_b_ff;
   vec4_type                 v_in;
   vec4_type                 v_ff;

   always_comb begin
      for (int r = 0; r < 4; r++) begin
         prod_x_in[r] = signed'(col_x[r]) * signed'({1'b0, screen_x});
         prod_y_in[r] = signed'(col_y[r]) * signed'({1'b0, screen_y});
      end
   end

   always_comb begin
      for (int r = 0; r < 4; r++) begin
         v_in[r] = VW'(prod_x_ff[r]) + VW'(prod_y_ff[r])
                 + (VW'(signed'(col_c[r])) <<< COORD_FRAC);
      end
   end

   always_ff @(posedge clock) begin
      for (int r = 0; r < 4; r++) begin
         prod_x_ff[r] <= prod_x_in[r];
         prod_y_ff[r] <= prod_y_in[r];
      end
      v_ff <= v_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
         valid_b_ff <= 1'b0;
      end else begin
         valid_a_ff <= in_valid;
         valid_b_ff <= valid_a_ff;
      end
   end

   assign out_valid = valid_b_ff;
   assign v         = v_ff;

endmodule

[src/crg_persp_div.sv]
// Pipelined perspective divide of three lanes by a shared w, two quotient bits a stage.
// Depends on crg_pkg.
module crg_persp_div import crg_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   input  vec4_type  v,
   output logic      out_valid,
   output logic      out_wzero,
   output world_type world
);

   // Magnitudes and signs
   logic                  p1_valid_ff;
   logic                  p1_wzero_in, p1_wzero_ff;
   logic [2:0][MAG_W-1:0] p1_a_in, p1_a_ff;
   logic [MAG_W-1:0]      p1_b_in, p1_b_ff;
   logic [2:0]            p1_neg_in, p1_neg_ff;

   // Division pipeline; index 0 holds the initial partial remainders
   logic [PREM_W-1:0]    rem_in [PDIV_STAGES+1][3];
   logic [PREM_W-1:0]    rem_ff [PDIV_STAGES+1][3];
   logic [PDIV_BITS-1:0] quo_in [PDIV_STAGES+1][3];
   logic [PDIV_BITS-1:0] quo_ff [PDIV_STAGES+1][3];
   logic [PDIV_BITS-1:0] nb_in  [PDIV_STAGES+1][3];
   logic [PDIV_BITS-1:0] nb_ff  [PDIV_STAGES+1][3];
   logic [MAG_W-1:0]     b_ff   [PDIV_STAGES+1];
   logic [2:0]           neg_ff [PDIV_STAGES+1];
   logic [2:0]           sat_in;
   logic [2:0]           sat_ff [PDIV_STAGES+1];
   logic                 wzero_ff [PDIV_STAGES+1];
   logic                 valid_ff [PDIV_STAGES+1];

   world_type            world_in, world_ff;
   logic                 out_valid_ff, out_wzero_ff;

   function automatic logic [MAG_W-1:0] vec_mag(input logic [VW-1:0] x);
      logic [VW-1:0] t;
      t = x[VW-1] ? (~x + 1'b1) : x;
      return t[MAG_W-1:0];
   endfunction

   always_comb begin
      for (int l = 0; l < 3; l++) begin
         p1_a_in[l]   = vec_mag(v[l]);
         p1_neg_in[l] = v[l][VW-1] ^ v[3][VW-1];
      end
      p1_b_in     = vec_mag(v[3]);
      p1_wzero_in = (v[3] == '0);
   end

   // The quotient overflows exactly when |v| >= |w| * 2^31.
   always_comb begin : div_steps
      logic [MAG_W+MATRIX_FRAC-1:0] num;
      logic [PREM_W-1:0]            r;
      logic [PREM_W-1:0]            t;
      logic [PDIV_BITS-1:0]         q;
      logic [PDIV_BITS-1:0]         n;
      for (int l = 0; l < 3; l++) begin
         sat_in[l] = (p1_b_ff[MAG_W-1:MAG_W-SAT_SHIFT] == '0)
                  && (p1_a_ff[l] >= {p1_b_ff[MAG_W-SAT_SHIFT-1:0], SAT_SHIFT'(0)});
         num = {p1_a_ff[l], MATRIX_FRAC'(0)};
         rem_in[0][l] = PREM_W'(num[MAG_W+MATRIX_FRAC-1:PDIV_BITS]);
         quo_in[0][l] = '0;
         nb_in[0][l]  = num[PDIV_BITS-1:0];
      end
      for (int s = 1; s <= PDIV_STAGES; s++) begin
         for (int l = 0; l < 3; l++) begin
            r = rem_ff[s-1][l];
            q = quo_ff[s-1][l];
            n = nb_ff[s-1][l];
            for (int k = 0; k < PDIV_STEPS; k++) begin
               t = {r[PREM_W-2:0], n[PDIV_BITS-1]};
               n = n << 1;
               if (t >= {1'b0, b_ff[s-1]}) begin
                  r = t - {1'b0, b_ff[s-1]};
                  q = {q[PDIV_BITS-2:0], 1'b1};
               end else begin
                  r = t;
                  q = {q[PDIV_BITS-2:0], 1'b0};
               end
            end
            rem_in[s][l] = r;
            quo_in[s][l] = q;
            nb_in[s][l]  = n;
         end
      end
   end

   always_comb begin : final_sign
      logic [WORLD_W-2:0] m;
      for (int l = 0; l < 3; l++) begin
         m = sat_ff[PDIV_STAGES][l] ? WORLD_MAX : quo_ff[PDIV_STAGES][l][WORLD_W-2:0];
         world_in[l] = neg_ff[PDIV_STAGES][l] ? (~{1'b0, m} + 1'b1) : {1'b0, m};
      end
   end

   always_ff @(posedge clock) begin
      p1_a_ff     <= p1_a_in;
      p1_b_ff     <= p1_b_in;
      p1_neg_ff   <= p1_neg_in;
      p1_wzero_ff <= p1_wzero_in;
      b_ff[0]     <= p1_b_ff;
      neg_ff[0]   <= p1_neg_ff;
      sat_ff[0]   <= sat_in;
      wzero_ff[0] <= p1_wzero_ff;
      for (int s = 0; s <= PDIV_STAGES; s++) begin
         for (int l = 0; l < 3; l++) begin
            rem_ff[s][l] <= rem_in[s][l];
            quo_ff[s][l] <= quo_in[s][l];
            nb_ff[s][l]  <= nb_in[s][l];
         end
      end
      for (int s = 1; s <= PDIV_STAGES; s++) begin
         b_ff[s]     <= b_ff[s-1];
         neg_ff[s]   <= neg_ff[s-1];
         sat_ff[s]   <= sat_ff[s-1];
         wzero_ff[s] <= wzero_ff[s-1];
      end
      world_ff     <= world_in;
      out_wzero_ff <= wzero_ff[PDIV_STAGES];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         for (int s = 0; s <= PDIV_STAGES; s++) begin
            valid_ff[s] <= 1'b0;
         end
      end else begin
         p1_valid_ff <= in_valid;
         valid_ff[0] <= p1_valid_ff;
         for (int s = 1; s <= PDIV_STAGES; s++) begin
            valid_ff[s] <= valid_ff[s-1];
         end
         out_valid_ff <= valid_ff[PDIV_STAGES];
      end
   end

   assign out_valid = out_valid_ff;
   assign out_wzero = out_wzero_ff;
   assign world     = world_ff;

endmodule

[src/crg_normalize.sv]
// Eye subtraction, common block-shift of the three magnitudes and sum of squares.
// Depends on crg_pkg.
module crg_normalize import crg_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  logic             in_wzero,
   input  world_type        world,
   input  eye_type          eye,
   output ray_side_type     side,
   output logic [SUM_W-1:0] sum
);

   logic [2:0][DIFF_W-1:0] n1_d_in, n1_d_ff;
   logic                   n1_valid_ff, n1_degen_ff;

   logic [2:0][MG_W-1:0]   n2_mg_in, n2_mg_ff;
   logic [2:0]             n2_neg_in, n2_neg_ff;
   logic                   n2_valid_ff, n2_degen_ff;

   logic [MG_W-1:0]        n3_or;
   logic [POS_W-1:0]       n3_pos_in, n3_pos_ff;
   logic [2:0][MG_W-1:0]   n3_mg_ff;
   logic [2:0]             n3_neg_ff;
   logic                   n3_valid_ff, n3_degen_ff;

   logic [2:0][NORM_W-1:0] n4_mag_in;
   ray_side_type           n4_side_ff, n5_side_ff, n6_side_ff;
   logic [2:0][SQ_W-1:0]   n5_sq_in, n5_sq_ff;
   logic [SUM_W-1:0]       n6_sum_in, n6_sum_ff;

   always_comb begin
      for (int l = 0; l < 3; l++) begin
         n1_d_in[l] = DIFF_W'(signed'(world[l])) - DIFF_W'(signed'(eye[l]));
      end
   end

   always_comb begin : mag_calc
      logic [DIFF_W-1:0] t;
      for (int l = 0; l < 3; l++) begin
         t = n1_d_ff[l][DIFF_W-1] ? (~n1_d_ff[l] + 1'b1) : n1_d_ff[l];
         n2_mg_in[l]  = t[MG_W-1:0];
         n2_neg_in[l] = n1_d_ff[l][DIFF_W-1];
      end
   end

   // The leading one of the OR of the magnitudes is that of the largest one.
   always_comb begin
      n3_or     = n2_mg_ff[0] | n2_mg_ff[1] | n2_mg_ff[2];
      n3_pos_in = '0;
      for (int i = 0; i < MG_W; i++) begin
         if (n3_or[i]) begin
            n3_pos_in = POS_W'(i);
         end
      end
   end

   always_comb begin : block_shift
      logic [MG_W-1:0] t;
      for (int l = 0; l < 3; l++) begin
         if (n3_pos_ff >= POS_W'(NORM_W - 1)) begin
            t = n3_mg_ff[l] >> (n3_pos_ff - POS_W'(NORM_W - 1));
         end else begin
            t = n3_mg_ff[l] << (POS_W'(NORM_W - 1) - n3_pos_ff);
         end
         n4_mag_in[l] = t[NORM_W-1:0];
      end
   end

   always_comb begin
      for (int l = 0; l < 3; l++) begin
         n5_sq_in[l] = n4_side_ff.mag[l] * n4_side_ff.mag[l];
      end
      n6_sum_in = SUM_W'(n5_sq_ff[0]) + SUM_W'(n5_sq_ff[1]) + SUM_W'(n5_sq_ff[2]);
   end

   always_ff @(posedge clock) begin
      n1_d_ff          <= n1_d_in;
      n1_degen_ff      <= in_wzero;
      n2_mg_ff         <= n2_mg_in;
      n2_neg_ff        <= n2_neg_in;
      n2_degen_ff      <= n1_degen_ff;
      n3_mg_ff         <= n2_mg_ff;
      n3_neg_ff        <= n2_neg_ff;
      n3_pos_ff        <= n3_pos_in;
      n3_degen_ff      <= n2_degen_ff | (n3_or == '0);
      n4_side_ff.degen <= n3_degen_ff;
      n4_side_ff.neg   <= n3_neg_ff;
      n4_side_ff.mag   <= n4_mag_in;
      n5_side_ff.degen <= n4_side_ff.degen;
      n5_side_ff.neg   <= n4_side_ff.neg;
      n5_side_ff.mag   <= n4_side_ff.mag;
      n5_sq_ff         <= n5_sq_in;
      n6_side_ff.degen <= n5_side_ff.degen;
      n6_side_ff.neg   <= n5_side_ff.neg;
      n6_side_ff.mag   <= n5_side_ff.mag;
      n6_sum_ff        <= n6_sum_in;
      if (reset) begin
         n1_valid_ff      <= 1'b0;
         n2_valid_ff      <= 1'b0;
         n3_valid_ff      <= 1'b0;
         n4_side_ff.valid <= 1'b0;
         n5_side_ff.valid <= 1'b0;
         n6_side_ff.valid <= 1'b0;
      end else begin
         n1_valid_ff      <= in_valid;
         n2_valid_ff      <= n1_valid_ff;
         n3_valid_ff      <= n2_valid_ff;
         n4_side_ff.valid <= n3_valid_ff;
         n5_side_ff.valid <= n4_side_ff.valid;
         n6_side_ff.valid <= n5_side_ff.valid;
      end
   end

   assign side = n6_side_ff;
   assign sum  = n6_sum_ff;

endmodule

[src/crg_isqrt.sv]
// Pipelined integer square root, two result bits a stage, carrying the lane data along.
// Depends on crg_pkg.
module crg_isqrt import crg_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  ray_side_type     in_side,
   input  logic [SUM_W-1:0] sum,
   output ray_side_type     out_side,
   output logic [LEN_W-1:0] len
);

   logic [RT_REM_W-1:0] rem_in  [SQRT_STAGES];
   logic [RT_REM_W-1:0] rem_ff  [SQRT_STAGES];
   logic [ROOT_W-1:0]   root_in [SQRT_STAGES];
   logic [ROOT_W-1:0]   root_ff [SQRT_STAGES];
   logic [SQ_IN_W-1:0]  rad_in  [SQRT_STAGES];
   logic [SQ_IN_W-1:0]  rad_ff  [SQRT_STAGES];
   ray_side_type        side_ff [SQRT_STAGES];

   always_comb begin : root_steps
      logic [RT_REM_W-1:0] r;
      logic [RT_REM_W-1:0] trial;
      logic [ROOT_W-1:0]   q;
      logic [SQ_IN_W-1:0]  n;
      for (int s = 0; s < SQRT_STAGES; s++) begin
         if (s == 0) begin
            r = '0;
            q = '0;
            n = SQ_IN_W'(sum);
         end else begin
            r = rem_ff[s-1];
            q = root_ff[s-1];
            n = rad_ff[s-1];
         end
         for (int k = 0; k < SQRT_STEPS; k++) begin
            r     = {r[RT_REM_W-3:0], n[SQ_IN_W-1:SQ_IN_W-2]};
            n     = n << 2;
            trial = {q, 2'b01};
            if (r >= trial) begin
               r = r - trial;
               q = {q[ROOT_W-2:0], 1'b1};
            end else begin
               q = {q[ROOT_W-2:0], 1'b0};
            end
         end
         rem_in[s]  = r;
         root_in[s] = q;
         rad_in[s]  = n;
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < SQRT_STAGES; s++) begin
         rem_ff[s]  <= rem_in[s];
         root_ff[s] <= root_in[s];
         rad_ff[s]  <= rad_in[s];
      end
      side_ff[0].degen <= in_side.degen;
      side_ff[0].neg   <= in_side.neg;
      side_ff[0].mag   <= in_side.mag;
      for (int s = 1; s < SQRT_STAGES; s++) begin
         side_ff[s].degen <= side_ff[s-1].degen;
         side_ff[s].neg   <= side_ff[s-1].neg;
         side_ff[s].mag   <= side_ff[s-1].mag;
      end
      if (reset) begin
         for (int s = 0; s < SQRT_STAGES; s++) begin
            side_ff[s].valid <= 1'b0;
         end
      end else begin
         side_ff[0].valid <= in_side.valid;
         for (int s = 1; s < SQRT_STAGES; s++) begin
            side_ff[s].valid <= side_ff[s-1].valid;
         end
      end
   end

   assign out_side = side_ff[SQRT_STAGES-1];
   assign len      = root_ff[SQRT_STAGES-1][LEN_W-1:0];

endmodule

[src/crg_unit_div.sv]
// Rounded division of the three magnitudes by the length, then sign and Q1.15 clamp.
// Depends on crg_pkg.
module crg_unit_div import crg_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  ray_side_type     in_side,
   input  logic [LEN_W-1:0] len,
   output logic             out_valid,
   output logic [DIR_W-1:0] dir_x,
   output logic [DIR_W-1:0] dir_y,
   output logic [DIR_W-1:0] dir_z,
   output logic             degenerate
);

   logic [UREM_W-1:0]  rem_in [UDIV_STAGES+1][3];
   logic [UREM_W-1:0]  rem_ff [UDIV_STAGES+1][3];
   logic [UQ_BITS-1:0] quo_in [UDIV_STAGES+1][3];
   logic [UQ_BITS-1:0] quo_ff [UDIV_STAGES+1][3];
   logic [UQ_BITS-1:0] nb_in  [UDIV_STAGES+1][3];
   logic [UQ_BITS-1:0] nb_ff  [UDIV_STAGES+1][3];
   logic [LEN_W-1:0]   len_ff [UDIV_STAGES+1];
   logic [2:0]         neg_ff [UDIV_STAGES+1];
   logic               degen_ff [UDIV_STAGES+1];
   logic               valid_ff [UDIV_STAGES+1];

   logic [2:0][DIR_W-1:0] dir_in, dir_ff;
   logic                  degen_out_ff, valid_out_ff;

   // Index 0 takes the rounded numerator mag*2^15 + len/2, mag being the block-shifted |d|.
   always_comb begin : div_steps
      logic [NUM_W-1:0]   num;
      logic [UREM_W-1:0]  r;
      logic [UREM_W-1:0]  t;
      logic [UQ_BITS-1:0] q;
      logic [UQ_BITS-1:0] n;
      for (int l = 0; l < 3; l++) begin
         num = NUM_W'({in_side.mag[l], DIR_FRAC'(0)}) + NUM_W'(len >> 1);
         rem_in[0][l] = UREM_W'(num[NUM_W-1:UQ_BITS]);
         quo_in[0][l] = '0;
         nb_in[0][l]  = num[UQ_BITS-1:0];
      end
      for (int s = 1; s <= UDIV_STAGES; s++) begin
         for (int l = 0; l < 3; l++) begin
            r = rem_ff[s-1][l];
            q = quo_ff[s-1][l];
            n = nb_ff[s-1][l];
            for (int k = 0; k < UDIV_STEPS; k++) begin
               t = {r[UREM_W-2:0], n[UQ_BITS-1]};
               n = n << 1;
               if (t >= {1'b0, len_ff[s-1]}) begin
                  r = t - {1'b0, len_ff[s-1]};
                  q = {q[UQ_BITS-2:0], 1'b1};
               end else begin
                  r = t;
                  q = {q[UQ_BITS-2:0], 1'b0};
               end
            end
            rem_in[s][l] = r;
            quo_in[s][l] = q;
            nb_in[s][l]  = n;
         end
      end
   end

   // A negative unit component may reach -1.0; a positive one stops just below.
   always_comb begin : clamp
      logic [UQ_BITS-1:0] q;
      logic [UQ_BITS-1:0] t;
      for (int l = 0; l < 3; l++) begin
         q = quo_ff[UDIV_STAGES][l];
         if (degen_ff[UDIV_STAGES]) begin
            t = '0;
         end else if (neg_ff[UDIV_STAGES][l]) begin
            t = ~((q > DIR_NEG_MAX) ? DIR_NEG_MAX : q) + 1'b1;
         end else begin
            t = (q > DIR_POS_MAX) ? DIR_POS_MAX : q;
         end
         dir_in[l] = t[DIR_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s <= UDIV_STAGES; s++) begin
         for (int l = 0; l < 3; l++) begin
            rem_ff[s][l] <= rem_in[s][l];
            quo_ff[s][l] <= quo_in[s][l];
            nb_ff[s][l]  <= nb_in[s][l];
         end
      end
      len_ff[0]   <= len;
      neg_ff[0]   <= in_side.neg;
      degen_ff[0] <= in_side.degen;
      for (int s = 1; s <= UDIV_STAGES; s++) begin
         len_ff[s]   <= len_ff[s-1];
         neg_ff[s]   <= neg_ff[s-1];
         degen_ff[s] <= degen_ff[s-1];
      end
      dir_ff       <= dir_in;
      degen_out_ff <= degen_ff[UDIV_STAGES];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_out_ff <= 1'b0;
         for (int s = 0; s <= UDIV_STAGES; s++) begin
            valid_ff[s] <= 1'b0;
         end
      end else begin
         valid_ff[0] <= in_side.valid;
         for (int s = 1; s <= UDIV_STAGES; s++) begin
            valid_ff[s] <= valid_ff[s-1];
         end
         valid_out_ff <= valid_ff[UDIV_STAGES];
      end
   end

   assign out_valid  = valid_out_ff;
   assign dir_x      = dir_ff[0];
   assign dir_y      = dir_ff[1];
   assign dir_z      = dir_ff[2];
   assign degenerate = degen_out_ff;

endmodule

[verif/tb_camera_ray_generator_unit.sv]
// Self-checking testbench for camera_ray_generator_unit: screen positions in, unit ray
// directions out, checked against an in-bench predictor. Depends on crg_pkg and the RTL.
`timescale 1ns / 1ps

module tb_camera_ray_generator_unit;
   import crg_pkg::*;

   typedef enum logic [1:0] {OP_RAY, OP_CSR, OP_IDLE} op_kind_type;

   typedef struct {
      op_kind_type            kind;
      logic [SCR_W-1:0]       sx;
      logic [SCR_W-1:0]       sy;
      logic [REG_IDX_W-1:0]   idx;
      logic [CSR_DATA_W-1:0]  data;
      int                     pct;
   } job_type;

   typedef struct {
      logic [DIR_W-1:0] dx;
      logic [DIR_W-1:0] dy;
      logic [DIR_W-1:0] dz;
      logic             degen;
   } ray_type;

   localparam longint unsigned WORLD_LIMIT = (64'd1 << 47) - 1;
   localparam int STALL_LIMIT = 5000;

   logic                  clock, reset, start, busy;
   logic [SCR_W-1:0]      req_screen_x, req_screen_y;
   logic                  rsp_strobe, rsp_degenerate;
   logic [DIR_W-1:0]      rsp_dir_x, rsp_dir_y, rsp_dir_z;
   logic                  psel, penable, pwrite, pready;
   logic [ADDR_W-1:0]     paddr;
   logic [CSR_DATA_W-1:0] pwdata, prdata;

   camera_ray_generator_unit dut (.*);

   job_type         pending_jobs[$];
   ray_type         expected_rays[$];
   logic [CSR_DATA_W-1:0] cam_regs [NUM_REGS];
   int              mismatches, rays_sent, rays_seen, degen_seen, csr_writes, quiet_cycles;
   int              idle_pct;
   int              apb_phase;
   logic            ray_taken;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   task automatic report_mismatch(input string what);
      $display("MISMATCH at %0t: %s", $realtime, what);
      mismatches++;
   endtask

   function automatic longint half_word(input logic [CSR_DATA_W-1:0] word, input int hi);
      logic [31:0] part;
      part = hi ? word[63:32] : word[31:0];
      return longint'($signed(part));
   endfunction

   function automatic longint unsigned magnitude(input longint v);
      return v < 0 ? longint'(0) - v : v;
   endfunction

   // Transform, perspective divide, normalisation, square root and rounding of one screen position.
   function automatic ray_type predict_ray(input logic [SCR_W-1:0] sx,
                                           input logic [SCR_W-1:0] sy);
      longint                v[4];
      longint                eye[3];
      longint                d[3];
      longint                world;
      longint unsigned       mg[3];
      longint unsigned       m, total, len, q, a, b, rem, wq, bitv, nrem;
      longint                xs, ys;
      int                    r, k;
      ray_type               res;
      res = '{dx: '0, dy: '0, dz: '0, degen: 1'b1};
      xs = longint'({1'b0, sx});
      ys = longint'({1'b0, sy});
      for (r = 0; r < 4; r++) begin
         v[r] = half_word(cam_regs[r >> 1], r & 1) * xs
              + half_word(cam_regs[2 + (r >> 1)], r & 1) * ys
              + half_word(cam_regs[4 + (r >> 1)], r & 1) * (longint'(1) << COORD_FRAC);
      end
      eye[0] = half_word(cam_regs[REG_EYE_XY], 0);
      eye[1] = half_word(cam_regs[REG_EYE_XY], 1);
      eye[2] = half_word(cam_regs[REG_EYE_Z], 0);
      if (v[3] == 0) return res;
      m = 0;
      for (r = 0; r < 3; r++) begin
         a = magnitude(v[r]);
         b = magnitude(v[3]);
         wq = a / b;
         rem = a % b;
         if (wq > (WORLD_LIMIT >> MATRIX_FRAC)) begin
            wq = WORLD_LIMIT;
         end else begin
            for (k = 0; k < MATRIX_FRAC; k++) begin
               rem = rem << 1;
               wq = wq << 1;
               if (rem >= b) begin
                  rem -= b;
                  wq |= 1;
               end
            end
            if (wq > WORLD_LIMIT) wq = WORLD_LIMIT;
         end
         world = ((v[r] < 0) != (v[3] < 0)) ? -longint'(wq) : longint'(wq);
         d[r] = world - eye[r];
         mg[r] = magnitude(d[r]);
         if (mg[r] > m) m = mg[r];
      end
      if (m == 0) return res;
      while (m >= (64'd1 << 30)) begin
         m >>= 1;
         for (r = 0; r < 3; r++) mg[r] >>= 1;
      end
      while (m < (64'd1 << 29)) begin
         m <<= 1;
         for (r = 0; r < 3; r++) mg[r] <<= 1;
      end
      total = mg[0] * mg[0] + mg[1] * mg[1] + mg[2] * mg[2];
      len = 0;
      nrem = total;
      bitv = 64'd1 << 62;
      while (bitv > nrem) bitv >>= 2;
      while (bitv != 0) begin
         if (nrem >= len + bitv) begin
            nrem -= len + bitv;
            len = (len >> 1) + bitv;
         end else begin
            len >>= 1;
         end
         bitv >>= 2;
      end
      for (r = 0; r < 3; r++) begin
         q = ((mg[r] << DIR_FRAC) + (len >> 1)) / len;
         if (d[r] < 0) begin
            if (q > 32768) q = 32768;
            q = longint'(0) - q;
         end else if (q > 32767) begin
            q = 32767;
         end
         if (r == 0) res.dx = q[15:0];
         else if (r == 1) res.dy = q[15:0];
         else res.dz = q[15:0];
      end
      res.degen = 1'b0;
      return res;
   endfunction

   // Driver: one beat or one register write at a time, inputs change on the falling edge.
   always @(negedge clock) begin
      logic nxt_start;
      job_type job;
      nxt_start = start;
      if (!reset) begin
         if (start && !ray_taken) begin
            nxt_start = 1'b1;
         end else begin
            nxt_start = 1'b0;
            if (apb_phase == 1) begin
               penable <= 1'b1;
               apb_phase = 2;
            end else if (apb_phase == 2) begin
               psel <= 1'b0;
               penable <= 1'b0;
               pwrite <= 1'b0;
               apb_phase = 0;
            end else if (pending_jobs.size() > 0) begin
               job = pending_jobs[0];
               case (job.kind)
                  OP_IDLE: begin
                     idle_pct = job.pct;
                     void'(pending_jobs.pop_front());
                  end
                  OP_CSR: begin
                     // Registers only change once every beat in flight has come back.
                     if (expected_rays.size() == 0) begin
                        psel <= 1'b1;
                        pwrite <= 1'b1;
                        paddr <= {job.idx, 3'b000};
                        pwdata <= job.data;
                        apb_phase = 1;
                        void'(pending_jobs.pop_front());
                     end
                  end
                  default: begin
                     if ($urandom_range(99, 0) >= idle_pct) begin
                        req_screen_x <= job.sx;
                        req_screen_y <= job.sy;
                        nxt_start = 1'b1;
                        void'(pending_jobs.pop_front());
                     end
                  end
               endcase
            end
         end
      end
      start <= nxt_start;
   end

   // Monitor: predicts on every accepted beat, tracks register writes, checks results.
   always @(posedge clock) begin
      ray_type want;
      ray_taken = 1'b0;
      if (!reset) begin
         quiet_cycles++;
         if (start && !busy) begin
            ray_taken = 1'b1;
            expected_rays.push_back(predict_ray(req_screen_x, req_screen_y));
            rays_sent++;
            quiet_cycles = 0;
         end
         if (psel && penable && pwrite && pready) begin
            cam_regs[paddr[ADDR_W-1:3]] = (paddr[ADDR_W-1:3] == REG_EYE_Z) ?
                                          {32'd0, pwdata[31:0]} : pwdata;
            csr_writes++;
            quiet_cycles = 0;
         end
         if (rsp_strobe) begin
            quiet_cycles = 0;
            rays_seen++;
            if (rsp_degenerate) degen_seen++;
            if (expected_rays.size() == 0) begin
               report_mismatch("result beat with no ray outstanding");
            end else begin
               want = expected_rays.pop_front();
               if (rsp_dir_x !== want.dx)
                  report_mismatch($sformatf("dir_x %h, expected %h", rsp_dir_x, want.dx));
               if (rsp_dir_y !== want.dy)
                  report_mismatch($sformatf("dir_y %h, expected %h", rsp_dir_y, want.dy));
               if (rsp_dir_z !== want.dz)
                  report_mismatch($sformatf("dir_z %h, expected %h", rsp_dir_z, want.dz));
               if (rsp_degenerate !== want.degen)
                  report_mismatch($sformatf("degenerate %b, expected %b",
                                            rsp_degenerate, want.degen));
            end
         end
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog expired with %0d rays outstanding", expected_rays.size());
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   task automatic add_ray(input logic [SCR_W-1:0] sx, input logic [SCR_W-1:0] sy);
      pending_jobs.push_back('{kind: OP_RAY, sx: sx, sy: sy, idx: '0, data: '0, pct: 0});
   endtask

   task automatic add_csr(input logic [REG_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      pending_jobs.push_back('{kind: OP_CSR, sx: '0, sy: '0, idx: idx, data: data, pct: 0});
   endtask

   task automatic add_idle(input int pct);
      pending_jobs.push_back('{kind: OP_IDLE, sx: '0, sy: '0, idx: '0, data: '0, pct: pct});
   endtask

   function automatic logic [31:0] pick_entry(input int flavour);
      case (flavour)
         0: return $urandom();
         1: return 32'($signed($urandom_range(32'h40000, 0)) - 32'sh20000);
         2: return ($urandom_range(1, 0) != 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
         default: return ($urandom_range(3, 0) == 0) ? 32'd0 : 32'hFFFF_FFFF;
      endcase
   endfunction

   function automatic logic [SCR_W-1:0] pick_coord();
      case ($urandom_range(7, 0))
         0: return '0;
         1: return '1;
         2: return SCR_W'($urandom_range(255, 0));
         default: return SCR_W'($urandom());
      endcase
   endfunction

   initial begin
      logic [REG_IDX_W-1:0] r;
      int p, n, flavour;
      reset = 1'b1;
      start = 1'b0;
      req_screen_x = '0;
      req_screen_y = '0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      mismatches = 0;
      rays_sent = 0;
      rays_seen = 0;
      degen_seen = 0;
      csr_writes = 0;
      quiet_cycles = 0;
      idle_pct = 0;
      apb_phase = 0;
      ray_taken = 1'b0;
      for (int i = 0; i < NUM_REGS; i++) cam_regs[i] = '0;
      cam_regs[REG_COL_C23] = COL_C23_RESET;

      // Reset values: the world point sits on the eye, so every ray is degenerate.
      add_ray('0, '0);
      add_ray('1, '1);
      // Identity-like mapping with the image plane one unit ahead of the eye.
      add_csr(REG_COL_X01, 64'h0000_0000_0001_0000);
      add_csr(REG_COL_X23, 64'd0);
      add_csr(REG_COL_Y01, 64'h0001_0000_0000_0000);
      add_csr(REG_COL_Y23, 64'd0);
      add_csr(REG_COL_C01, 64'd0);
      add_csr(REG_COL_C23, 64'h0001_0000_0001_0000);
      add_csr(REG_EYE_XY, 64'd0);
      add_csr(REG_EYE_Z, 64'd0);
      add_ray('0, '0);
      add_ray('1, '1);
      add_ray('1, '0);
      add_ray('0, '1);
      add_ray(16'd16, '0);
      add_ray(16'h8000, 16'h0001);
      // Eye on the world point, then behind it: zero difference and a negative unit.
      add_csr(REG_EYE_Z, 64'h0000_0000_0001_0000);
      add_ray('0, '0);
      add_csr(REG_EYE_Z, 64'h0000_0000_0002_0000);
      add_ray('0, '0);
      add_ray(16'd32, 16'd48);
      // Large x column against a tiny w drives the quotient into saturation.
      add_csr(REG_COL_C23, 64'h0000_0001_0000_0000);
      add_csr(REG_COL_X01, 64'h0000_0000_7FFF_FFFF);
      add_ray('1, '0);
      add_csr(REG_COL_X01, 64'h8000_0000_8000_0000);
      add_ray('1, '1);
      // Row 3 all zero gives a zero w.
      add_csr(REG_COL_C23, 64'd0);
      add_ray(16'd5, 16'd5);
      add_ray('1, '1);

      for (p = 0; p < 6; p++) begin
         add_idle((p % 3 == 0) ? 0 : (p % 3 == 1) ? 47 : 37);
         for (int i = 0; i < NUM_REGS; i++) begin
            r = REG_IDX_W'(i);
            flavour = (p == 4) ? 3 : (p == 5) ? 2 : $urandom_range(1, 0);
            add_csr(r, {pick_entry(flavour), pick_entry(flavour)});
         end
         n = 120;
         for (int j = 0; j < n; j++) begin
            // Half way through each phase, swap in a new eye, forcing the sender to wait for
            // every outstanding ray first.
            if (j == n / 2)
               add_csr(REG_EYE_Z, {$urandom(), pick_entry($urandom_range(1, 0))});
            add_ray(pick_coord(), pick_coord());
         end
      end

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      while (pending_jobs.size() != 0 || apb_phase != 0 || start ||
             expected_rays.size() != 0) begin
         @(posedge clock);
      end
      repeat (80) @(posedge clock);
      $display("Covered %0d rays (%0d degenerate) over %0d register writes,", rays_sent,
               degen_seen, csr_writes);
      $display("including saturation, zero w, zero difference and idle phases.");
      if (mismatches == 0 && expected_rays.size() == 0 && rays_seen == rays_sent) begin
         $display("end of test: clean");
      end else begin
         $display("%0d mismatches, %0d rays unanswered", mismatches, expected_rays.size());
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
